### sv/cqr_pkg.sv
// cqr_pkg: types, codes and constants shared by the circular queue with replace
// used by cqr_ctrl, cqr_datapath and circular_queue_with_replace
`default_nettype none

package cqr_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int DATA_W        = 32;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_DELETE  = 2'd1,
      OP_MODIFY  = 2'd2,
      OP_DISPLAY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
      logic signed [DATA_W-1:0]  new_value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  data;
      logic                      last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;      // latch request, start scan at head
      logic       issue_read;  // read entry at scan pointer, step pointer
      logic       write_ins;   // write value at tail, push
      logic       write_mod;   // overwrite scanned entry with new_value
      logic       pop;         // drop oldest entry
      logic       emit;        // load result register
      status_type emit_status;
      logic       emit_rd;     // result data from read entry, else zero
      logic       emit_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   match;      // read entry equals searched value
      logic   left_zero;  // no held entry after the one just read
      logic   out_free;   // result register can take an item this cycle
   } sts_type;

endpackage

`default_nettype wire

### sv/cqr_ctrl.sv
// cqr_ctrl: sequencing state machine of the circular queue with replace
// depends on cqr_pkg; drives cqr_datapath through cmd_type, reads sts_type
`default_nettype none

module cqr_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  cqr_pkg::sts_type     sts,
   output cqr_pkg::cmd_type     cmd
);
   import cqr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.emit_status = STAT_OK;
      req_stall       = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.op == OP_INSERT) begin
               if (sts.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = sts.full ? STAT_FULL : STAT_OK;
                  cmd.write_ins   = !sts.full;
                  state_in        = ST_IDLE;
               end
            end else if (sts.empty) begin
               if (sts.out_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = STAT_EMPTY;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.issue_read = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            case (sts.op)
               OP_DELETE: begin
                  if (sts.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_rd   = 1'b1;
                     cmd.emit_last = 1'b1;
                     cmd.pop       = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               OP_MODIFY: begin
                  if (sts.match) begin
                     if (sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        cmd.write_mod = 1'b1;
                        state_in      = ST_IDLE;
                     end
                  end else if (sts.left_zero) begin
                     if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = STAT_NOTFOUND;
                        state_in        = ST_IDLE;
                     end
                  end else begin
                     cmd.issue_read = 1'b1;
                  end
               end
               OP_DISPLAY: begin
                  if (sts.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_rd   = 1'b1;
                     cmd.emit_last = sts.left_zero;
                     if (sts.left_zero) begin
                        state_in = ST_IDLE;
                     end else begin
                        cmd.issue_read = 1'b1;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/cqr_datapath.sv
// cqr_datapath: entry memory, head/tail/count, scan pointer and result register
// depends on cqr_pkg; commanded by cqr_ctrl
`default_nettype none

module cqr_datapath #(
   parameter int DEPTH = cqr_pkg::DEPTH_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  cqr_pkg::req_type     req_item,
   input  wire logic            rsp_stall,
   output logic                 rsp_valid,
   output cqr_pkg::rsp_type     rsp_item,
   input  cqr_pkg::cmd_type     cmd,
   output cqr_pkg::sts_type     sts
);
   import cqr_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];

   req_type           req_ff;
   logic [ADDR_W-1:0] head_ff, tail_ff, ptr_ff, addr_ff;
   logic [CNT_W-1:0]  count_ff, left_ff;
   logic [DATA_W-1:0] rd_data_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;

   function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
      return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + 1'b1;
   endfunction

   assign wr_en   = cmd.write_ins | cmd.write_mod;
   assign wr_addr = cmd.write_ins ? tail_ff : addr_ff;
   assign wr_data = cmd.write_ins ? req_ff.value : req_ff.new_value;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.issue_read) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_item;
      end
      if (cmd.issue_read) begin
         addr_ff <= ptr_ff;
      end
   end

   // scan pointer restarts at head for every item
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
         left_ff  <= '0;
      end else begin
         if (cmd.accept) begin
            ptr_ff  <= head_ff;
            left_ff <= count_ff;
         end else if (cmd.issue_read) begin
            ptr_ff  <= wrap_inc(ptr_ff);
            left_ff <= left_ff - 1'b1;
         end
         if (cmd.write_ins) begin
            tail_ff  <= wrap_inc(tail_ff);
            count_ff <= count_ff + 1'b1;
         end else if (cmd.pop) begin
            head_ff  <= wrap_inc(head_ff);
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in.status = cmd.emit_status;
      rsp_in.data   = cmd.emit_rd ? rd_data_ff : '0;
      rsp_in.last   = cmd.emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      sts.op        = req_ff.op;
      sts.empty     = (count_ff == '0);
      sts.full      = (count_ff == CNT_W'(DEPTH));
      sts.match     = (rd_data_ff == req_ff.value);
      sts.left_zero = (left_ff == '0);
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule

`default_nettype wire

### sv/circular_queue_with_replace.sv
// Circular queue of DEPTH signed 32-bit entries with insert, delete, modify
// (replace first match, oldest first) and display (every entry, oldest first,
// last marked). One item is taken at a time. Insert loads its result in the
// decode state; delete reads the oldest entry there and loads its result in
// the scan state. Modify reads entries in the scan state until a match or
// the end (up to DEPTH entries). Display loads one result a cycle while the
// output does not stall. Delete, modify or display on an empty queue loads
// its result in the decode state. The next item can be accepted in the cycle
// after the final result load. Entries come from the single-port entry
// memory, read one entry a cycle while no output stall holds the scan, with
// registered read data. A result waits in an output register while the
// output stalls, which holds up the item. The next item is accepted while the
// last result is still there.
// Depends on cqr_pkg, cqr_ctrl and cqr_datapath.
`default_nettype none

module circular_queue_with_replace #(
   parameter int DEPTH = cqr_pkg::DEPTH_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  cqr_pkg::req_type     req_item,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output cqr_pkg::rsp_type     rsp_item
);
   import cqr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cqr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cqr_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .sts       (sts)
   );

   // one item in flight: stall right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another was in flight");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded over a waiting result");

   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_ins, cmd.write_mod, cmd.issue_read}))
      else $error("conflicting memory accesses");

   a_count_sane: assert property (@(posedge clock) disable iff (reset)
      !(sts.full && sts.empty))
      else $error("queue reported full and empty");

endmodule

`default_nettype wire
